[hdl/oce_pkg.sv]
// ----------------------------------------------------------------------------
// oce_pkg
// Shared types, constants and decode for the ones' complement execute unit.
// ----------------------------------------------------------------------------
package oce_pkg;

    localparam int WORD_W     = 16;
    localparam int PC_W       = 10;
    localparam int NUM_REGS   = 8;
    localparam int REG_AW     = 3;
    // program depth, a power of two of at most 2**PC_W
    localparam int PROG_DEPTH = 1024;

    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = 2;
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = 1;

    // opcode bit positions in the instruction word
    localparam int BIT_A = 12;
    localparam int BIT_B = 11;
    localparam int BIT_C = 10;
    localparam int BIT_D = 9;

    typedef enum logic [3:0] {
        OP_SHR,
        OP_SHL,
        OP_ADD,
        OP_PRINT,
        OP_JUMP,
        OP_BGE,
        OP_BGT,
        OP_BLE,
        OP_BLT,
        OP_NOT,
        OP_OR,
        OP_AND,
        OP_MOV,
        OP_MOVI
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    wr;
        logic [REG_AW-1:0]       ra;
        logic [REG_AW-1:0]       rb;
        logic [REG_AW-1:0]       rd;
        logic [WORD_W-1:0]       follow;
    } dec_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              print_valid;
        logic [WORD_W-1:0] print_value;
        logic              overflow;
    } res_t;

    function automatic op_t decode_op(input logic [WORD_W-1:0] iw);
        logic a;
        logic b;
        logic c;
        logic d;
        op_t  op;
        a = iw[BIT_A];
        b = iw[BIT_B];
        c = iw[BIT_C];
        d = iw[BIT_D];
        if (a && b && c && d)  op = OP_SHR;
        else if (a && b && c)  op = OP_SHL;
        else if (a && c && d)  op = OP_ADD;
        else if (a && c)       op = OP_PRINT;
        else if (a && d)       op = OP_JUMP;
        else if (a)            op = OP_BGE;
        else if (b && c && d)  op = OP_BGT;
        else if (b && c)       op = OP_BLE;
        else if (b && d)       op = OP_BLT;
        else if (b)            op = OP_NOT;
        else if (c && d)       op = OP_OR;
        else if (c)            op = OP_AND;
        else if (d)            op = OP_MOV;
        else                   op = OP_MOVI;
        return op;
    endfunction

    // keep a target inside the program space, then to the pc width
    function automatic logic [PC_W-1:0] wrap_pc(input logic [WORD_W:0] addr);
        logic [WORD_W:0] masked;
        masked = addr & (WORD_W+1)'(PROG_DEPTH - 1);
        return masked[PC_W-1:0];
    endfunction

endpackage

[hdl/oce_ram.sv]
// ----------------------------------------------------------------------------
// oce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module oce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/oce_front.sv]
// ----------------------------------------------------------------------------
// oce_front
// Accepts instruction items, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
module oce_front
    import oce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] instr_word,
    input  logic [WORD_W-1:0] follow_word,
    output logic              iq_valid,
    output dec_t              iq_head,
    input  logic              iq_pop
);

    dec_t             iq_mem_reg [IQ_DEPTH];
    logic [IQ_AW-1:0] wr_ptr_reg;
    logic [IQ_AW-1:0] wr_ptr_next;
    logic [IQ_AW-1:0] rd_ptr_reg;
    logic [IQ_AW-1:0] rd_ptr_next;
    logic [IQ_AW:0]   count_reg;
    logic [IQ_AW:0]   count_next;
    logic             do_push;
    logic             do_pop;
    dec_t             dec;

    always_comb
    begin
        dec.op     = decode_op(instr_word);
        dec.ra     = instr_word[5:3];
        dec.rb     = instr_word[2:0];
        dec.follow = follow_word;
        dec.rd     = instr_word[2:0];
        dec.wr     = 1'b0;
        unique case (dec.op)
            OP_SHR, OP_SHL, OP_MOVI:
            begin
                dec.rd = instr_word[2:0];
                dec.wr = 1'b1;
            end
            OP_ADD, OP_OR, OP_AND:
            begin
                dec.rd = instr_word[8:6];
                dec.wr = 1'b1;
            end
            OP_NOT, OP_MOV:
            begin
                dec.rd = instr_word[5:3];
                dec.wr = 1'b1;
            end
            default:
            begin
                dec.wr = 1'b0;
            end
        endcase
    end

    assign full     = (count_reg == (IQ_AW+1)'(IQ_DEPTH));
    assign iq_valid = (count_reg != '0);
    assign iq_head  = iq_mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = iq_pop && iq_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (IQ_AW+1)'(do_push) - (IQ_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            iq_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[hdl/oce_back.sv]
// ----------------------------------------------------------------------------
// oce_back
// Reads operands, executes decoded items, updates registers and pc, and
// queues the result items.
// ----------------------------------------------------------------------------
module oce_back
    import oce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic iq_valid,
    input  dec_t iq_head,
    output logic iq_pop,
    output logic empty,
    input  logic pop,
    output res_t out_head
);

    // execute stage
    logic              b_valid_reg;
    dec_t              b_item_reg;
    logic              fwd_x_reg;
    logic              fwd_y_reg;
    logic [WORD_W-1:0] fwd_val_reg;
    logic              vld_x_reg;
    logic              vld_y_reg;
    logic              b_done;

    logic [NUM_REGS-1:0] reg_valid_reg;
    logic [PC_W-1:0]     pc_reg;

    logic [WORD_W-1:0] ram_x;
    logic [WORD_W-1:0] ram_y;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;

    logic              wr_en;
    logic [WORD_W-1:0] wr_val;
    res_t              res;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] add_res;
    logic              add_ovf;
    logic              take;
    logic              is_branch;
    logic [WORD_W:0]   seq_pc;

    // result queue
    res_t             oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_ptr_reg;
    logic [OQ_AW-1:0] oq_rd_ptr_reg;
    logic [OQ_AW:0]   oq_count_reg;
    logic             oq_full;
    logic             oq_pop;

    assign oq_full = (oq_count_reg == (OQ_AW+1)'(OQ_DEPTH));
    assign b_done  = b_valid_reg && !oq_full;
    assign iq_pop  = iq_valid && (!b_valid_reg || b_done);
    assign wr_en   = b_done && b_item_reg.wr;

    oce_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_ram_x (
        .clk   (clk),
        .we    (wr_en),
        .waddr (b_item_reg.rd),
        .wdata (wr_val),
        .re    (iq_pop),
        .raddr (iq_head.ra),
        .rdata (ram_x)
    );

    oce_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_ram_y (
        .clk   (clk),
        .we    (wr_en),
        .waddr (b_item_reg.rd),
        .wdata (wr_val),
        .re    (iq_pop),
        .raddr (iq_head.rb),
        .rdata (ram_y)
    );

    // never-written registers read as zero
    always_comb
    begin
        x = fwd_x_reg ? fwd_val_reg : (vld_x_reg ? ram_x : '0);
        y = fwd_y_reg ? fwd_val_reg : (vld_y_reg ? ram_y : '0);
    end

    always_comb
    begin
        // end-around carry added back once
        sum     = {1'b0, x} + {1'b0, y};
        add_res = sum[WORD_W-1:0] + WORD_W'(sum[WORD_W]);
        add_ovf = (x[WORD_W-1] == y[WORD_W-1]) && (add_res[WORD_W-1] != x[WORD_W-1]);
        seq_pc  = (WORD_W+1)'(pc_reg) + (WORD_W+1)'(1);
        wr_val    = '0;
        take      = 1'b0;
        is_branch = 1'b0;
        res.print_valid = 1'b0;
        res.print_value = '0;
        res.overflow    = 1'b0;
        unique case (b_item_reg.op)
            OP_SHR:
            begin
                wr_val = {y[15], y[15], y[14:1]};
            end
            OP_SHL:
            begin
                wr_val = {y[15], y[13:0], y[15]};
            end
            OP_ADD:
            begin
                wr_val       = add_ovf ? '0 : add_res;
                res.overflow = add_ovf;
            end
            OP_PRINT:
            begin
                res.print_valid = 1'b1;
                res.print_value = y;
            end
            OP_JUMP:
            begin
                is_branch = 1'b1;
                take      = 1'b1;
            end
            OP_BGE:
            begin
                is_branch = 1'b1;
                take      = $signed(x) >= $signed(y);
            end
            OP_BGT:
            begin
                is_branch = 1'b1;
                take      = $signed(x) > $signed(y);
            end
            OP_BLE:
            begin
                is_branch = 1'b1;
                take      = $signed(x) <= $signed(y);
            end
            OP_BLT:
            begin
                is_branch = 1'b1;
                take      = $signed(x) < $signed(y);
            end
            OP_NOT:
            begin
                wr_val = ~y;
            end
            OP_OR:
            begin
                wr_val = x | y;
            end
            OP_AND:
            begin
                wr_val = x & y;
            end
            OP_MOV:
            begin
                wr_val = y;
            end
            OP_MOVI:
            begin
                wr_val = b_item_reg.follow;
                seq_pc = (WORD_W+1)'(pc_reg) + (WORD_W+1)'(2);
            end
            default:
            begin
                wr_val = '0;
            end
        endcase
        if (take)
        begin
            res.next_pc = wrap_pc({1'b0, b_item_reg.follow});
        end
        else if (is_branch)
        begin
            res.next_pc = wrap_pc((WORD_W+1)'(pc_reg) + (WORD_W+1)'(2));
        end
        else
        begin
            res.next_pc = wrap_pc(seq_pc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            reg_valid_reg <= '0;
            pc_reg        <= '0;
        end
        else
        begin
            if (iq_pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                reg_valid_reg[b_item_reg.rd] <= 1'b1;
            end
            if (b_done)
            begin
                pc_reg <= res.next_pc;
            end
        end
    end

    // operand capture, with bypass of a write landing in the same cycle
    always_ff @(posedge clk)
    begin
        if (iq_pop)
        begin
            b_item_reg  <= iq_head;
            fwd_val_reg <= wr_val;
            fwd_x_reg   <= wr_en && (b_item_reg.rd == iq_head.ra);
            fwd_y_reg   <= wr_en && (b_item_reg.rd == iq_head.rb);
            vld_x_reg   <= reg_valid_reg[iq_head.ra];
            vld_y_reg   <= reg_valid_reg[iq_head.rb];
        end
    end

    assign empty    = (oq_count_reg == '0);
    assign out_head = oq_mem_reg[oq_rd_ptr_reg];
    assign oq_pop   = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (b_done)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
            oq_count_reg <= oq_count_reg + (OQ_AW+1)'(b_done) - (OQ_AW+1)'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_done)
        begin
            oq_mem_reg[oq_wr_ptr_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue count beyond depth");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_done) |=> (b_valid_reg && $stable(b_item_reg)))
        else $error("execute stage lost its item while stalled");

    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> reg_valid_reg[$past(b_item_reg.rd)])
        else $error("written register not marked valid");

    a_pc_moves: assert property (@(posedge clk) disable iff (!rst_n)
        b_done |=> (pc_reg == $past(res.next_pc)))
        else $error("pc not updated by finished item");
`endif

endmodule

[hdl/ones_complement_cpu_execute_unit.sv]
// ----------------------------------------------------------------------------
// ones_complement_cpu_execute_unit
// Executes one instruction of a ones' complement register machine per item.
//
// channel   direction  handshake        payload
// input     in         push / full      instr_word, follow_word
// result    out        empty / pop      next_pc, print_valid, print_value,
//                                       overflow
//
// one item per cycle sustained while results are popped and neither queue fills;
// an item passes the input queue, the operand read from the registered-read
// register file and execute into the result queue before its result is on the ports
// reset clears the registers, pc and both queues; no clearing pass
// input and result sides stall independently through the two queues
// ----------------------------------------------------------------------------
module ones_complement_cpu_execute_unit
    import oce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] instr_word,
    input  logic [WORD_W-1:0] follow_word,
    output logic              empty,
    input  logic              pop,
    output logic [PC_W-1:0]   next_pc,
    output logic              print_valid,
    output logic [WORD_W-1:0] print_value,
    output logic              overflow
);

    logic iq_valid;
    dec_t iq_head;
    logic iq_pop;
    res_t out_head;

    oce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .instr_word  (instr_word),
        .follow_word (follow_word),
        .iq_valid    (iq_valid),
        .iq_head     (iq_head),
        .iq_pop      (iq_pop)
    );

    oce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .iq_valid (iq_valid),
        .iq_head  (iq_head),
        .iq_pop   (iq_pop),
        .empty    (empty),
        .pop      (pop),
        .out_head (out_head)
    );

    assign next_pc     = out_head.next_pc;
    assign print_valid = out_head.print_valid;
    assign print_value = out_head.print_value;
    assign overflow    = out_head.overflow;

endmodule
